FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/bpru_pkg.sv
// ----------------------------------------------------------------------------
// bpru_pkg
// Shared constants and command format of the BMP pixel replicate upscaler.
// ----------------------------------------------------------------------------
package bpru_pkg;

    localparam int HEADER_BYTES    = 54;
    localparam int SIZE_FIRST      = 18;
    localparam int SIZE_LAST       = 25;
    localparam int SIZE_HELD       = 7;
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int MAX_SCALE_DEF   = 16;
    localparam int CMD_DEPTH       = 4;

    localparam logic [15:0] HEIGHT_CLAMP = 16'hFFFF;

    localparam logic [1:0] CMD_PASS  = 2'd0;
    localparam logic [1:0] CMD_SIZE  = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] data;      // pass: [7:0], size: {oh, ow}, pixel: {r, g, b}
        logic        err;
        logic [5:0]  tri_len;   // pixel bytes before output padding
        logic [5:0]  last_idx;  // index of final byte of the run
    } cmd_t;

endpackage

FILE: rtl/bpru_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bpru_cmd_fifo
// Short command queue between the parser front end and the byte expander.
// ----------------------------------------------------------------------------
module bpru_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  bpru_pkg::cmd_t wr_data,
    input  logic           rd_en,
    output bpru_pkg::cmd_t rd_data,
    output logic           full,
    output logic           not_empty
);
    import bpru_pkg::*;

    localparam int AW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    cmd_t          mem [CMD_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/bpru_front.sv
// ----------------------------------------------------------------------------
// bpru_front
// Stream parser: tracks header and pixel position, emits one command per
// input byte that produces output.
// ----------------------------------------------------------------------------
module bpru_front #(
    parameter int MAX_WIDTH = bpru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = bpru_pkg::MAX_SCALE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           file_start,
    input  logic [4:0]     scale,
    output logic           cmd_valid,
    output bpru_pkg::cmd_t cmd
);
    import bpru_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [5:0]    hpos_reg, hpos_next, hpos_cur;
    logic [WW-1:0] width_reg, width_next, width_cur;
    logic [15:0]   height_reg, height_next, height_cur;
    logic [WW-1:0] col_reg, col_next, col_cur;
    logic [1:0]    phase_reg, phase_next, phase_cur;
    logic [15:0]   bg_reg, bg_next, bg_cur;
    logic [1:0]    pad_reg, pad_next, pad_cur;
    logic [19:0]   rows_reg, rows_next, rows_cur;
    logic          werr_reg, werr_next, werr_cur;

    logic [7:0]    size_mem [SIZE_HELD];
    logic          size_we;
    logic [5:0]    size_off;

    logic [4:0]    s_eff;
    logic [20:0]   rows_limit;
    logic [31:0]   w_word, h_word;
    logic [36:0]   prod_w, prod_h;
    logic          active;
    logic [WW:0]   col_inc;
    logic          row_end;
    logic [3:0]    op_prod;
    logic [1:0]    out_pad;
    logic [5:0]    tri_len;
    logic          emit;

    always_comb
    begin
        if (scale == 5'd0)
        begin
            s_eff = 5'd1;
        end
        else if (scale > 5'(MAX_SCALE))
        begin
            s_eff = 5'(MAX_SCALE);
        end
        else
        begin
            s_eff = scale;
        end
    end

    assign hpos_cur   = file_start ? '0 : hpos_reg;
    assign width_cur  = file_start ? '0 : width_reg;
    assign height_cur = file_start ? '0 : height_reg;
    assign col_cur    = file_start ? '0 : col_reg;
    assign phase_cur  = file_start ? '0 : phase_reg;
    assign bg_cur     = file_start ? '0 : bg_reg;
    assign pad_cur    = file_start ? '0 : pad_reg;
    assign rows_cur   = file_start ? '0 : rows_reg;
    assign werr_cur   = file_start ? 1'b0 : werr_reg;

    assign rows_limit = height_cur * s_eff;
    assign w_word     = {size_mem[3], size_mem[2], size_mem[1], size_mem[0]};
    assign h_word     = {in_byte, size_mem[6], size_mem[5], size_mem[4]};
    assign prod_w     = w_word * s_eff;
    assign prod_h     = h_word * s_eff;
    assign active     = !werr_cur && (width_cur != '0) && ({1'b0, rows_cur} < rows_limit);
    assign col_inc    = {1'b0, col_cur} + 1'b1;
    assign row_end    = (col_inc >= {1'b0, width_cur});
    assign op_prod    = width_cur[1:0] * s_eff[1:0];
    assign out_pad    = row_end ? op_prod[1:0] : 2'd0;
    assign tri_len    = 6'({1'b0, s_eff}) + 6'({s_eff, 1'b0});
    assign size_off   = hpos_cur - 6'(SIZE_FIRST);

    always_comb
    begin
        hpos_next   = hpos_cur;
        width_next  = width_cur;
        height_next = height_cur;
        col_next    = col_cur;
        phase_next  = phase_cur;
        bg_next     = bg_cur;
        pad_next    = pad_cur;
        rows_next   = rows_cur;
        werr_next   = werr_cur;
        size_we     = 1'b0;
        emit        = 1'b0;
        cmd         = '0;
        cmd.err     = werr_cur;

        if (hpos_cur < 6'(HEADER_BYTES))
        begin
            hpos_next = hpos_cur + 1'b1;
            if (hpos_cur >= 6'(SIZE_FIRST) && hpos_cur < 6'(SIZE_LAST))
            begin
                size_we = 1'b1;
            end
            else if (hpos_cur == 6'(SIZE_LAST))
            begin
                emit = 1'b1;
                if (w_word > 32'(MAX_WIDTH))
                begin
                    werr_next  = 1'b1;
                    width_next = '0;
                end
                else
                begin
                    width_next = WW'(w_word);
                end
                if (h_word[31])
                begin
                    height_next = '0;
                end
                else if (h_word[30:16] != '0)
                begin
                    height_next = HEIGHT_CLAMP;
                end
                else
                begin
                    height_next = h_word[15:0];
                end
                cmd.kind     = CMD_SIZE;
                cmd.data     = {prod_h[31:0], prod_w[31:0]};
                cmd.err      = werr_next;
                cmd.last_idx = 6'd7;
            end
            else
            begin
                emit          = 1'b1;
                cmd.kind      = CMD_PASS;
                cmd.data[7:0] = in_byte;
            end
        end
        else if (active)
        begin
            if (pad_cur != 2'd0)
            begin
                pad_next = pad_cur - 1'b1;
                if (pad_cur == 2'd1)
                begin
                    rows_next = rows_cur + 1'b1;
                end
            end
            else if (phase_cur == 2'd0)
            begin
                bg_next    = {bg_cur[15:8], in_byte};
                phase_next = 2'd1;
            end
            else if (phase_cur == 2'd1)
            begin
                bg_next    = {in_byte, bg_cur[7:0]};
                phase_next = 2'd2;
            end
            else
            begin
                emit           = 1'b1;
                cmd.kind       = CMD_PIXEL;
                cmd.data[23:0] = {in_byte, bg_cur};
                cmd.tri_len    = tri_len;
                cmd.last_idx   = tri_len + 6'(out_pad) - 6'd1;
                phase_next     = 2'd0;
                if (row_end)
                begin
                    col_next = '0;
                    pad_next = width_cur[1:0];
                    if (width_cur[1:0] == 2'd0)
                    begin
                        rows_next = rows_cur + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_inc[WW-1:0];
                end
            end
        end
    end

    assign cmd_valid = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpos_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            phase_reg  <= '0;
            bg_reg     <= '0;
            pad_reg    <= '0;
            rows_reg   <= '0;
            werr_reg   <= 1'b0;
        end
        else if (accept)
        begin
            hpos_reg   <= hpos_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            phase_reg  <= phase_next;
            bg_reg     <= bg_next;
            pad_reg    <= pad_next;
            rows_reg   <= rows_next;
            werr_reg   <= werr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && size_we)
        begin
            size_mem[size_off[2:0]] <= in_byte;
        end
    end

endmodule

FILE: rtl/bpru_back.sv
// ----------------------------------------------------------------------------
// bpru_back
// Byte expander: turns one queued command into its run of output bytes.
// ----------------------------------------------------------------------------
module bpru_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_avail,
    input  bpru_pkg::cmd_t cmd,
    output logic           cmd_take,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           header_error
);
    import bpru_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    cmd_t       cur_reg;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] phase_reg, phase_next;
    logic       done;

    assign empty        = !cur_valid_reg;
    assign run_last     = (cnt_reg == cur_reg.last_idx);
    assign header_error = cur_reg.err;
    assign done         = pop && cur_valid_reg && run_last;
    assign cmd_take     = cmd_avail && (!cur_valid_reg || done);

    always_comb
    begin
        unique case (cur_reg.kind)
            CMD_PASS:
            begin
                out_byte = cur_reg.data[7:0];
            end
            CMD_SIZE:
            begin
                out_byte = cur_reg.data[{cnt_reg[2:0], 3'b000} +: 8];
            end
            CMD_PIXEL:
            begin
                if (cnt_reg < cur_reg.tri_len)
                begin
                    case (phase_reg)
                        2'd0:    out_byte = cur_reg.data[7:0];
                        2'd1:    out_byte = cur_reg.data[15:8];
                        default: out_byte = cur_reg.data[23:16];
                    endcase
                end
                else
                begin
                    out_byte = 8'h00;
                end
            end
            default:
            begin
                out_byte = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        if (cmd_take)
        begin
            cur_valid_next = 1'b1;
            cnt_next       = '0;
            phase_next     = '0;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (pop && cur_valid_reg)
        begin
            cnt_next   = cnt_reg + 1'b1;
            phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_reg <= cmd;
        end
    end

endmodule

FILE: rtl/bmp_pixel_replicate_upscaler_unit.sv
// ----------------------------------------------------------------------------
// bmp_pixel_replicate_upscaler_unit: commands are queued, then registered in the expander.
// Input: 1 byte/cycle while the 4-entry command queue has room.
// Output: 1 byte/cycle on pop with a run loaded; a pixel's 3rd byte gives 3*scale+0..3 bytes.
// Async active-low reset: parser at header byte 0, queue empty, scale = 1.
// ----------------------------------------------------------------------------
module bmp_pixel_replicate_upscaler_unit #(
    parameter int MAX_WIDTH = bpru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = bpru_pkg::MAX_SCALE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       file_start,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       header_error,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);
    import bpru_pkg::*;

    logic [4:0] scale_reg;
    logic       accept;
    logic       front_valid;
    cmd_t       front_cmd;
    cmd_t       fifo_cmd;
    logic       fifo_avail;
    logic       fifo_take;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 5'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_reg <= cfg_data;
        end
    end

    bpru_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .file_start (file_start),
        .scale      (scale_reg),
        .cmd_valid  (front_valid),
        .cmd        (front_cmd)
    );

    bpru_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_valid),
        .wr_data   (front_cmd),
        .rd_en     (fifo_take),
        .rd_data   (fifo_cmd),
        .full      (full),
        .not_empty (fifo_avail)
    );

    bpru_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_avail    (fifo_avail),
        .cmd          (fifo_cmd),
        .cmd_take     (fifo_take),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .header_error (header_error)
    );

endmodule

FILE: rtl/bpru_checker.sv
// ----------------------------------------------------------------------------
// bpru_checker
// Port-level checks of the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpru_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       pop,
    input logic       empty,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       header_error
);

    // a full queue always has a run in the expander
    `ASSERT_IMPLIES(a_full_not_empty, clk, rst_n, full, !empty)

    // with no accepted input, an empty expander stays empty
    `ASSERT_NEXT(a_no_spurious, clk, rst_n, empty && $past(empty) && !(push && !full) && !$past(push && !full), empty)

    // a run continues until its last byte
    `ASSERT_NEXT(a_run_continues, clk, rst_n, !empty && pop && !run_last, !empty && header_error == $past(header_error))

    // stalled result holds
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_byte) && $stable(run_last))

endmodule

bind bmp_pixel_replicate_upscaler_unit bpru_checker u_bpru_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .header_error (header_error)
);
